// File: rtl/core/bbca_pkg.sv
// Package for the byte bin color averager: bin record type, queue status,
// class colors and the saturating sum helper. No dependencies.
`timescale 1ns / 1ps

package bbca_pkg;

    localparam int SUM_W   = 24;
    localparam int CNT_W   = 16;
    localparam int CHAN_W  = 8;
    localparam int MAX_BIN = 65535;
    // quotient bits: 8 result bits plus one saturation bit
    localparam int QUO_W   = CHAN_W + 1;

    localparam logic [CHAN_W-1:0] CTRL_MAX  = 8'h1f;
    localparam logic [CHAN_W-1:0] PRINT_MAX = 8'h7f;
    localparam logic [CHAN_W-1:0] BYTE_FF   = 8'hff;
    localparam logic [CHAN_W-1:0] CLASS_ADD = 8'hf0;
    localparam logic [CHAN_W-1:0] ALL_ADD   = 8'hff;
    localparam logic [CHAN_W-1:0] GRAY_RB   = 8'd20;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hff;

    localparam logic REG_BIN_SIZE   = 1'b0;
    localparam logic REG_CLASS_MODE = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] red_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] blue_sum;
        logic [CNT_W-1:0] count;
        logic             class_mode;
        logic             last;
    } bin_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [CHAN_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W-CHAN_W+1){1'b0}}, v};
        sat_add = t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

// File: rtl/core/bbca_front.sv
// Front end: config registers, byte classing and per-bin accumulation.
// Depends on bbca_pkg; pushes closed bins into bbca_queue.
`timescale 1ns / 1ps

module bbca_front
    import bbca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAN_W-1:0] byte_value,
    input  logic              end_of_data,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [CNT_W-1:0]  wr_data,
    input  q_stat_t           q_stat,
    output logic              push,
    output bin_t              push_data
);

    logic [CNT_W-1:0] bin_size_reg, bin_size_next;
    logic             class_mode_reg, class_mode_next;
    logic [SUM_W-1:0] red_sum_reg, red_sum_next;
    logic [SUM_W-1:0] green_sum_reg, green_sum_next;
    logic [SUM_W-1:0] blue_sum_reg, blue_sum_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic             emit;
    logic [CNT_W-1:0] eff_bin;
    logic [CNT_W-1:0] count_inc;
    logic [SUM_W-1:0] red_acc, green_acc, blue_acc;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        eff_bin = (bin_size_reg == '0) ? CNT_W'(1) : bin_size_reg;
        if (32'(eff_bin) > MAX_BIN)
        begin
            eff_bin = CNT_W'(MAX_BIN);
        end
    end

    always_comb
    begin
        red_acc   = red_sum_reg;
        green_acc = green_sum_reg;
        blue_acc  = blue_sum_reg;
        if (class_mode_reg)
        begin
            priority if (byte_value == '0)
            begin
                red_acc = red_sum_reg;
            end
            else if (byte_value <= CTRL_MAX)
            begin
                blue_acc = sat_add(blue_sum_reg, CLASS_ADD);
            end
            else if (byte_value <= PRINT_MAX)
            begin
                green_acc = sat_add(green_sum_reg, CLASS_ADD);
            end
            else if (byte_value != BYTE_FF)
            begin
                red_acc = sat_add(red_sum_reg, CLASS_ADD);
            end
            else
            begin
                red_acc   = sat_add(red_sum_reg, ALL_ADD);
                green_acc = sat_add(green_sum_reg, ALL_ADD);
                blue_acc  = sat_add(blue_sum_reg, ALL_ADD);
            end
        end
        else
        begin
            green_acc = sat_add(green_sum_reg, byte_value);
        end
    end

    // count cannot wrap: a bin closes no later than at the effective size
    assign count_inc = count_reg + CNT_W'(1);
    assign emit      = end_of_data || (count_inc >= eff_bin);
    assign push      = accept && emit;

    always_comb
    begin
        push_data.red_sum    = red_acc;
        push_data.green_sum  = green_acc;
        push_data.blue_sum   = blue_acc;
        push_data.count      = count_inc;
        push_data.class_mode = class_mode_reg;
        push_data.last       = end_of_data;
    end

    always_comb
    begin
        bin_size_next   = bin_size_reg;
        class_mode_next = class_mode_reg;
        red_sum_next    = red_sum_reg;
        green_sum_next  = green_sum_reg;
        blue_sum_next   = blue_sum_reg;
        count_next      = count_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_BIN_SIZE:   bin_size_next   = wr_data;
                REG_CLASS_MODE: class_mode_next = wr_data[0];
                default:        bin_size_next   = bin_size_reg;
            endcase
        end
        if (accept)
        begin
            if (emit)
            begin
                red_sum_next   = '0;
                green_sum_next = '0;
                blue_sum_next  = '0;
                count_next     = '0;
            end
            else
            begin
                red_sum_next   = red_acc;
                green_sum_next = green_acc;
                blue_sum_next  = blue_acc;
                count_next     = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_size_reg   <= CNT_W'(1);
            class_mode_reg <= 1'b1;
            red_sum_reg    <= '0;
            green_sum_reg  <= '0;
            blue_sum_reg   <= '0;
            count_reg      <= '0;
        end
        else
        begin
            bin_size_reg   <= bin_size_next;
            class_mode_reg <= class_mode_next;
            red_sum_reg    <= red_sum_next;
            green_sum_reg  <= green_sum_next;
            blue_sum_reg   <= blue_sum_next;
            count_reg      <= count_next;
        end
    end

endmodule

// File: rtl/core/bbca_queue.sv
// Short FIFO of closed bins between front and back end.
// Depends on bbca_pkg for the bin record and status types.
`timescale 1ns / 1ps

module bbca_queue
    import bbca_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bin_t    push_data,
    input  logic    pop,
    output bin_t    pop_data,
    output q_stat_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bin_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    assign q_stat.full  = (fill_reg == CW'(DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("bin pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("bin popped from empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// File: rtl/core/bbca_back.sv
// Back end: bit-serial restoring divide of three channel sums by the byte
// count, saturation, gray override and the output register. Uses bbca_pkg.
`timescale 1ns / 1ps

module bbca_back
    import bbca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_stat_t           q_stat,
    input  bin_t              pop_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue,
    output logic              final_pixel
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    localparam int STEP_W = $clog2(QUO_W);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  rem_reg [3];
    logic [SUM_W-1:0]  rem_next [3];
    logic [QUO_W-1:0]  quo_reg [3];
    logic [QUO_W-1:0]  quo_next [3];
    logic [SUM_W-1:0]  div_reg, div_next;
    logic              mode_reg, mode_next;
    logic              last_reg, last_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0] red_reg, red_next;
    logic [CHAN_W-1:0] green_reg, green_next;
    logic [CHAN_W-1:0] blue_reg, blue_next;
    logic              final_reg, final_next;

    logic              out_free;
    logic [CHAN_W-1:0] chan_res [3];

    assign out_free = !out_valid_reg || !out_stall;

    // a set top quotient bit means the mean is 256 or more
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            chan_res[i] = quo_reg[i][CHAN_W] ? CHAN_MAX : quo_reg[i][CHAN_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        div_next       = div_reg;
        mode_next      = mode_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        final_next     = final_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop         = 1'b1;
                    rem_next[0] = pop_data.red_sum;
                    rem_next[1] = pop_data.green_sum;
                    rem_next[2] = pop_data.blue_sum;
                    for (int i = 0; i < 3; i++)
                    begin
                        quo_next[i] = '0;
                    end
                    div_next   = {pop_data.count, {CHAN_W{1'b0}}};
                    step_next  = STEP_W'(QUO_W - 1);
                    mode_next  = pop_data.class_mode;
                    last_next  = pop_data.last;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[i] >= div_reg)
                    begin
                        rem_next[i] = rem_reg[i] - div_reg;
                        quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b0};
                    end
                end
                div_next = div_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    red_next       = mode_reg ? chan_res[0] : GRAY_RB;
                    green_next     = chan_res[1];
                    blue_next      = mode_reg ? chan_res[2] : GRAY_RB;
                    final_next     = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
        mode_reg  <= mode_next;
        last_reg  <= last_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        final_reg <= final_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign final_pixel = final_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg <= STEP_W'(QUO_W - 1)))
        else $error("divide step counter out of range");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_DIV))
        else $error("bin popped without starting a divide");

endmodule

// File: rtl/core/byte_bin_color_averager_top.sv
// Byte bin color averager, top level: front end, bin queue, divide back end.
// Throughput: one byte per cycle in while the queue is not full; the back end takes one bin at a time
// (load, 9 divide steps, output load), so short bins fill the queue and stall the input.
// Reset (rst_n, async low): sums, counts, queue fill and out_valid cleared; bin_size 1, class_mode 1.
`timescale 1ns / 1ps

module byte_bin_color_averager_top
    import bbca_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAN_W-1:0] byte_value,
    input  logic              end_of_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue,
    output logic              final_pixel,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [CNT_W-1:0]  wr_data
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    bin_t    push_data;
    bin_t    pop_data;

    bbca_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_value  (byte_value),
        .end_of_data (end_of_data),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    bbca_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    bbca_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .final_pixel (final_pixel)
    );

endmodule
